>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// assertion helper macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every edge outside reset
`define CHK_IMPL(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed");
`endif

>>> hw/rtl/vcrd_pkg.sv
// ----------------------------------------------------------------------------
// vcrd_pkg
// shared types and codes for the vector clock race detector
// ----------------------------------------------------------------------------
package vcrd_pkg;
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_MARK  = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_TAG,
		ST_LOOK,
		ST_BUMP_RD,
		ST_BUMP_WR,
		ST_ALLOC,
		ST_CHK_RD,
		ST_CHK_WR,
		ST_CHK_WAIT,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_DONE
	} state_t;
endpackage

>>> hw/rtl/vcrd_ram.sv
// ----------------------------------------------------------------------------
// vcrd_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module vcrd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> hw/rtl/vector_clock_race_detector_core.sv
// ----------------------------------------------------------------------------
// vector_clock_race_detector_core: one access per item, result strobed by done, no stall
// one item at a time, the next item can be taken in the cycle done is high
// reset: clear pass over max(BUCKETS*WAYS, THREADS*THREADS) addresses (512), busy high
// ----------------------------------------------------------------------------
module vector_clock_race_detector_core #(
	parameter int THREADS      = 8,
	parameter int BUCKETS      = 128,
	parameter int WAYS         = 4,
	parameter int EPOCH_BITS   = 32,
	parameter int ADDRESS_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [47:0] address,
	input  logic [2:0]  thread_id,
	input  logic        starts_region,
	output logic        done,
	output logic        race_found,
	output logic        address_racy,
	output logic        table_full
);
	import vcrd_pkg::*;

	localparam int TB   = $clog2(THREADS);
	localparam int BB   = $clog2(BUCKETS);
	localparam int WB   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT  = BUCKETS * WAYS;
	localparam int EB   = $clog2(ENT);
	localparam int VB   = EB + TB;
	localparam int VCD  = 1 << VB;
	localparam int TCB  = 2 * TB;
	localparam int TCD  = 1 << TCB;
	localparam int CLRN = (ENT > TCD) ? ENT : TCD;
	localparam int CB   = $clog2(CLRN);
	localparam int AB   = (ADDRESS_BITS < 48) ? ADDRESS_BITS : 48;
	localparam int TW   = AB + 2;
	localparam logic [EPOCH_BITS-1:0] EMAX = '1;

	// item registers
	logic [1:0]      op_q;
	logic [AB-1:0]   addr_q;
	logic [TB-1:0]   tid_q;
	logic            bump_q;
	logic            tid_bad_q;
	logic [BB-1:0]   set_q;

	// entry lookup: tag ram word is {valid, racy, address}
	logic [EB-1:0]   way_base;
	logic [WB-1:0]   way_q;
	logic [WB:0]     wcnt_q;
	logic            hit_q;
	logic            free_q;
	logic [WB-1:0]   free_way_q;
	logic [EB-1:0]   ent_q;
	logic            ent_racy_q;

	// slot counter for clock sweeps
	logic [TB:0]     slot_q;
	logic            ph_q;
	logic [CB:0]     clr_q;
	logic            ordered_q;
	logic            rd_phase_q;
	logic            found_q;
	logic [EPOCH_BITS-1:0] own_q;

	state_t state_q, state_d;

	// ram ports
	logic            tag_we;
	logic [EB-1:0]   tag_a;
	logic [TW-1:0]   tag_wd, tag_rd;
	logic            rc_we, wc_we, tc_we;
	logic [VB-1:0]   rc_a, wc_a;
	logic [TCB-1:0]  tc_a;
	logic [EPOCH_BITS-1:0] rc_wd, wc_wd, tc_wd, rc_rd, wc_rd, tc_rd;

	vcrd_ram #(.WIDTH(TW), .DEPTH(ENT)) u_tag (
		.clk(clk), .we(tag_we), .addr(tag_a), .wdata(tag_wd), .rdata(tag_rd));
	vcrd_ram #(.WIDTH(EPOCH_BITS), .DEPTH(VCD)) u_rc (
		.clk(clk), .we(rc_we), .addr(rc_a), .wdata(rc_wd), .rdata(rc_rd));
	vcrd_ram #(.WIDTH(EPOCH_BITS), .DEPTH(VCD)) u_wc (
		.clk(clk), .we(wc_we), .addr(wc_a), .wdata(wc_wd), .rdata(wc_rd));
	vcrd_ram #(.WIDTH(EPOCH_BITS), .DEPTH(TCD)) u_tc (
		.clk(clk), .we(tc_we), .addr(tc_a), .wdata(tc_wd), .rdata(tc_rd));

	// set index is a xor of the two low digits of the address
	logic [AB-1:0] in_addr;
	assign in_addr  = address[AB-1:0];
	assign way_base = EB'(set_q) * EB'(WAYS);

	// tag word fields of the way read a cycle ago
	logic          tag_valid, tag_racy;
	logic [AB-1:0] tag_addr;
	logic [WB-1:0] look_way;
	logic [EB-1:0] look_ent;
	assign tag_valid = tag_rd[TW-1];
	assign tag_racy  = tag_rd[TW-2];
	assign tag_addr  = tag_rd[AB-1:0];
	assign look_way  = wcnt_q[WB-1:0];
	assign look_ent  = way_base + EB'(look_way);

	// in the check sweep the compared slot is the slot the ram read in the previous cycle
	logic [TB-1:0] slot_i, slot_p;
	assign slot_i = slot_q[TB-1:0];
	assign slot_p = TB'(slot_q - (TB+1)'(1));

	// shared compare unit
	logic cmp_gt;
	logic [EPOCH_BITS-1:0] cmp_a, cmp_b;
	assign cmp_gt = cmp_a > cmp_b;

	always_comb begin
		state_d = state_q;
		tag_we  = 1'b0;
		tag_a   = way_base + EB'(way_q);
		tag_wd  = {1'b1, ent_racy_q, addr_q};
		rc_we = 1'b0; wc_we = 1'b0; tc_we = 1'b0;
		rc_a  = {ent_q, slot_i};
		wc_a  = {ent_q, slot_i};
		tc_a  = {tid_q, slot_i};
		rc_wd = '0; wc_wd = '0; tc_wd = '0;
		cmp_a = wc_rd; cmp_b = tc_rd;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_TAG;
			end
			ST_CLEAR: begin
				// zero tag words and thread clocks in one pass
				tag_a  = clr_q[EB-1:0];
				tag_wd = '0;
				tag_we = clr_q < (CB+1)'(ENT);
				tc_a   = clr_q[TCB-1:0];
				tc_we  = clr_q < (CB+1)'(TCD);
				if (clr_q == (CB+1)'(CLRN - 1)) state_d = ST_IDLE;
			end
			ST_TAG: state_d = ST_LOOK;
			ST_LOOK: begin
				// tag of way wcnt available in tag_rd
				if (wcnt_q == (WB+1)'(WAYS)) begin
					if (op_q == OP_QUERY || tid_bad_q) state_d = ST_DONE;
					else if (op_q != OP_MARK && bump_q) state_d = ST_BUMP_RD;
					else state_d = ST_ALLOC;
				end
			end
			ST_BUMP_RD: begin
				tc_a = {tid_q, tid_q};
				state_d = ST_BUMP_WR;
			end
			ST_BUMP_WR: begin
				// own epoch holds at its maximum
				tc_a  = {tid_q, tid_q};
				tc_we = tc_rd != EMAX;
				tc_wd = tc_rd + EPOCH_BITS'(1);
				state_d = ST_ALLOC;
			end
			ST_ALLOC: begin
				// new entry: zero both clocks, one slot a cycle
				if (!hit_q && free_q) begin
					rc_we = 1'b1; wc_we = 1'b1;
				end
				if (hit_q || !free_q || slot_q == (TB+1)'(THREADS - 1)) begin
					if (!hit_q && !free_q) state_d = ST_DONE;
					else if (op_q == OP_MARK || ent_racy_q) state_d = ST_DONE;
					else state_d = ST_CHK_RD;
				end
			end
			ST_CHK_RD: begin
				// issue reads, compare the slot read a cycle ago
				cmp_a = rd_phase_q ? rc_rd : wc_rd;
				if (slot_q == (TB+1)'(THREADS)) state_d = ST_CHK_WAIT;
			end
			ST_CHK_WAIT: begin
				if (op_q == OP_READ) state_d = ST_UPD_RD;
				else if (!ordered_q) state_d = ST_DONE;
				else if (!rd_phase_q) state_d = ST_CHK_RD;
				else state_d = ST_UPD_WR;
			end
			ST_UPD_RD: begin
				// read a slot, then own epoch into read clock and max into thread clock
				cmp_a = (slot_i == tid_q) ? own_q : rc_rd;
				cmp_b = tc_rd;
				if (ph_q) begin
					rc_we = slot_i == tid_q;
					rc_wd = own_q;
					tc_we = cmp_gt;
					tc_wd = cmp_a;
					if (slot_q == (TB+1)'(THREADS - 1)) state_d = ST_DONE;
				end
			end
			ST_UPD_WR: begin
				// read a slot, then max of thread clock into write clock
				cmp_a = tc_rd; cmp_b = wc_rd;
				if (ph_q) begin
					wc_we = cmp_gt;
					wc_wd = tc_rd;
					if (slot_q == (TB+1)'(THREADS - 1)) state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// write back valid, racy flag and address of a used entry
				tag_a   = ent_q;
				tag_we  = hit_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= state_q == ST_DONE;
			if (state_q == ST_CLEAR) clr_q <= clr_q + (CB+1)'(1);
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q       <= opcode;
				addr_q     <= in_addr;
				tid_q      <= TB'(thread_id);
				tid_bad_q  <= {29'd0, thread_id} >= 32'(THREADS);
				bump_q     <= starts_region;
				set_q      <= BB'(in_addr ^ (in_addr >> BB));
				way_q      <= '0;
				wcnt_q     <= '0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
				found_q    <= 1'b0;
				ent_racy_q <= 1'b0;
				slot_q     <= '0;
			end
			ST_TAG: begin
				way_q <= way_q + WB'(1);
			end
			ST_LOOK: begin
				if (wcnt_q != (WB+1)'(WAYS)) begin
					if (tag_valid && tag_addr == addr_q && !hit_q) begin
						hit_q      <= 1'b1;
						ent_q      <= look_ent;
						ent_racy_q <= tag_racy;
					end
					if (!tag_valid && !free_q) begin
						free_q     <= 1'b1;
						free_way_q <= look_way;
					end
					wcnt_q <= wcnt_q + (WB+1)'(1);
					way_q  <= way_q + WB'(1);
				end else if (!hit_q) begin
					ent_q <= way_base + EB'(free_way_q);
				end
			end
			ST_ALLOC: begin
				if (hit_q || !free_q || slot_q == (TB+1)'(THREADS - 1)) begin
					slot_q     <= '0;
					ordered_q  <= 1'b1;
					rd_phase_q <= 1'b0;
					if (!hit_q && free_q) hit_q <= 1'b1;
					if (op_q == OP_MARK && (hit_q || free_q)) ent_racy_q <= 1'b1;
				end else begin
					slot_q <= slot_q + (TB+1)'(1);
				end
			end
			ST_CHK_RD: begin
				if (slot_q != '0 && cmp_gt) ordered_q <= 1'b0;
				// own epoch is latched while the thread clock is swept
				if (slot_q != '0 && slot_p == tid_q) own_q <= tc_rd;
				slot_q <= slot_q + (TB+1)'(1);
			end
			ST_CHK_WAIT: begin
				if (!ordered_q) begin
					ent_racy_q <= 1'b1;
					found_q    <= 1'b1;
				end
				rd_phase_q <= 1'b1;
				slot_q     <= '0;
				ph_q       <= 1'b0;
			end
			ST_UPD_RD, ST_UPD_WR: begin
				ph_q <= !ph_q;
				if (ph_q) slot_q <= slot_q + (TB+1)'(1);
			end
			ST_DONE: begin
				race_found   <= found_q;
				table_full   <= !hit_q && op_q != OP_QUERY && !tid_bad_q;
				address_racy <= hit_q && ent_racy_q;
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;
endmodule

>>> hw/rtl/vcrd_checker.sv
// ----------------------------------------------------------------------------
// vcrd_checker
// port-level checks on the race detector core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module vcrd_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic race_found,
	input logic address_racy,
	input logic table_full
);
	`CHK_NEXT(a_take_busy, arst_n, start && !busy, busy)
	`CHK_IMPL(a_done_busy, arst_n, done, !busy)
	`CHK_IMPL(a_race_racy, arst_n, done && race_found, address_racy && !table_full)
	`CHK_IMPL(a_full_clean, arst_n, done && table_full, !address_racy && !race_found)
	`CHK_NEXT(a_done_pulse, arst_n, done, !done)
endmodule

bind vector_clock_race_detector_core vcrd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.race_found(race_found), .address_racy(address_racy), .table_full(table_full));
